### design/ffha_pkg.sv
// Shared constants, payload types and cell control types for the heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int MAX_REGIONS  = 64;
  // Both tables rotate in lockstep during a scan, so they have the same length.
  localparam int MAX_BLOCKS   = MAX_REGIONS;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 8;
  localparam int ADDR_BITS    = 16;

  localparam int SIZE_W  = ADDR_BITS + 1;
  localparam int WIDE_W  = SIZE_W + 1;
  localparam int OWNER_W = 8;
  localparam int IDX_W   = $clog2(MAX_REGIONS);
  localparam int COUNT_W = $clog2(MAX_REGIONS + 1);
  localparam int FRAG_W  = 7;

  localparam logic [SIZE_W-1:0] HEAP_LIMIT = SIZE_W'(2 ** ADDR_BITS);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;
  localparam logic [1:0] CMD_INIT  = 2'd3;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [SIZE_W-1:0]    req_size;
    logic [ADDR_BITS-1:0] block_addr;
    logic [OWNER_W-1:0]   task_id;
  } in_item_t;

  typedef struct packed {
    logic                 status;
    logic [ADDR_BITS-1:0] alloc_addr;
    logic [FRAG_W-1:0]    frag_count;
    logic [SIZE_W-1:0]    free_bytes;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    size;
  } region_ent_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    size;
    logic [OWNER_W-1:0]   owner;
  } block_ent_t;

  typedef struct packed {
    logic             rotate;
    logic             init;
    region_ent_t      init_ent;
    logic             mod_en;
    logic [IDX_W-1:0] mod_idx;
    region_ent_t      mod_ent;
    logic             rem_en;
    logic [IDX_W-1:0] rem_idx;
    logic             ins_en;
    logic [IDX_W-1:0] ins_idx;
    region_ent_t      ins_ent;
  } region_ctrl_t;

  typedef struct packed {
    logic             rotate;
    logic             init;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    block_ent_t       wr_ent;
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
  } block_ctrl_t;

  localparam region_ent_t REGION_RESET_ENT = '{
    valid: 1'b1,
    start: ADDR_BITS'(HEADER_BYTES),
    size:  HEAP_LIMIT - SIZE_W'(HEADER_BYTES)
  };

endpackage
`default_nettype wire

### design/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: command sequencer and the two cell rings.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data  (cmd, req_size, block_addr, task_id)
//   out     | output    | out_valid/out_stall| out_data (status, alloc_addr, frag_count,
//           |           |                    |           free_bytes)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_data (heap_bytes)
//
// For allocate, free and count, both tables rotate once through their head cell in
// ST_SCAN, then ST_APPLY applies the edit. Init goes straight to ST_APPLY.
// One command is in flight at a time; the next is taken once the result is registered.
// A stalled result holds the edit cycle until the output register frees up.
// Reset is synchronous and leaves one free region covering a 64 KiB heap past its first header.
`default_nettype none
module first_fit_heap_allocator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ffha_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ffha_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ffha_pkg::SIZE_W-1:0]       cfg_data
);
  import ffha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [SIZE_W-1:0]  heap_bytes;
  in_item_t           in_q;
  logic [IDX_W-1:0]   scan_idx;
  logic [SIZE_W-1:0]  sum;
  logic [FRAG_W-1:0]  frag;
  logic [COUNT_W-1:0] region_count;
  logic [COUNT_W-1:0] region_count_next;

  logic                 r_found;
  logic [IDX_W-1:0]     r_idx;
  logic [ADDR_BITS-1:0] r_start;
  logic [SIZE_W-1:0]    r_size;
  logic                 l_valid;
  logic [IDX_W-1:0]     l_idx;
  logic [ADDR_BITS-1:0] l_start;
  logic [SIZE_W-1:0]    l_size;
  logic                 b_found;
  logic [IDX_W-1:0]     b_idx;
  logic [SIZE_W-1:0]    b_size;
  logic [OWNER_W-1:0]   b_owner;

  region_ctrl_t rctrl;
  block_ctrl_t  bctrl;
  out_item_t    result;

  region_ent_t r_ent   [MAX_REGIONS];
  region_ent_t r_left  [MAX_REGIONS];
  region_ent_t r_right [MAX_REGIONS];
  block_ent_t  b_ent   [MAX_BLOCKS];
  block_ent_t  b_right [MAX_BLOCKS];

  logic in_take;
  logic scanning;
  logic apply_go;
  logic r_hit;
  logic b_hit;
  logic [WIDE_W-1:0] rounded_size;
  logic [WIDE_W-1:0] need;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign scanning  = (state == ST_SCAN);
  assign apply_go  = (state == ST_APPLY) && (!out_valid || !out_stall);

  assign rounded_size = (WIDE_W'(in_q.req_size) + WIDE_W'(ALIGN_BYTES - 1))
                        & ~WIDE_W'(ALIGN_BYTES - 1);
  assign need         = rounded_size + WIDE_W'(HEADER_BYTES);

  // Cell rings: during a scan every entry moves one place toward cell 0.
  for (genvar c = 0; c < MAX_REGIONS; c++) begin : g_region
    if (c == 0) begin : g_first
      assign r_left[c] = '0;
    end else begin : g_mid
      assign r_left[c] = r_ent[c-1];
    end
    if (c == MAX_REGIONS - 1) begin : g_last
      assign r_right[c] = scanning ? r_ent[0] : '0;
    end else begin : g_inner
      assign r_right[c] = r_ent[c+1];
    end
    ffha_region_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(c)),
      .ctrl     (rctrl),
      .left     (r_left[c]),
      .right    (r_right[c]),
      .ent      (r_ent[c])
    );
  end

  for (genvar c = 0; c < MAX_BLOCKS; c++) begin : g_block
    assign b_right[c] = b_ent[(c + 1) % MAX_BLOCKS];
    ffha_block_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(c)),
      .ctrl     (bctrl),
      .right    (b_right[c]),
      .ent      (b_ent[c])
    );
  end

  // Scan hits: first fitting region for allocate, first region at or past the
  // block for free; first empty block slot for allocate, matching block for free.
  assign r_hit = r_ent[0].valid && ((in_q.cmd == CMD_ALLOC) ?
                 (WIDE_W'(r_ent[0].size) >= need) : (r_ent[0].start >= in_q.block_addr));
  assign b_hit = (in_q.cmd == CMD_ALLOC) ? !b_ent[0].valid :
                 (b_ent[0].valid && b_ent[0].start == in_q.block_addr);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = (in_data.cmd == CMD_INIT) ? ST_APPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == IDX_W'(MAX_REGIONS - 1)) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Edit and result, worked out from the scan summary.
  always_comb begin
    logic              alloc_ok;
    logic              exact;
    logic              free_ok;
    logic              ml;
    logic              mr;
    logic [WIDE_W-1:0] hdr;
    logic [WIDE_W-1:0] bend;
    logic [WIDE_W-1:0] grow;
    logic [WIDE_W-1:0] lend;
    logic [SIZE_W-1:0] h;

    rctrl             = '0;
    bctrl             = '0;
    result            = '0;
    region_count_next = region_count;
    rctrl.rotate      = scanning;
    bctrl.rotate      = scanning;
    result.free_bytes = sum;

    alloc_ok = (in_q.req_size != '0) && b_found && r_found;
    exact    = (WIDE_W'(r_size) == need);
    hdr      = WIDE_W'(in_q.block_addr) - WIDE_W'(HEADER_BYTES);
    bend     = WIDE_W'(in_q.block_addr) + WIDE_W'(b_size);
    grow     = WIDE_W'(b_size) + WIDE_W'(HEADER_BYTES);
    lend     = WIDE_W'(l_start) + WIDE_W'(l_size);
    ml       = l_valid && (lend == hdr);
    mr       = r_found && (bend == WIDE_W'(r_start));
    free_ok  = (in_q.block_addr != '0) && b_found && (b_owner == in_q.task_id)
               && !(l_valid && lend > hdr) && !(r_found && bend > WIDE_W'(r_start))
               && (ml || mr || region_count < COUNT_W'(MAX_REGIONS));
    h        = (heap_bytes > HEAP_LIMIT) ? HEAP_LIMIT : heap_bytes;

    unique case (in_q.cmd)
      CMD_ALLOC: begin
        if (alloc_ok) begin
          if (exact) begin
            rctrl.rem_en      = 1'b1;
            rctrl.rem_idx     = r_idx;
            region_count_next = region_count - COUNT_W'(1);
          end else begin
            rctrl.mod_en  = 1'b1;
            rctrl.mod_idx = r_idx;
            rctrl.mod_ent = '{valid: 1'b1, start: ADDR_BITS'(WIDE_W'(r_start) + need),
                              size: SIZE_W'(WIDE_W'(r_size) - need)};
          end
          bctrl.wr_en  = 1'b1;
          bctrl.wr_idx = b_idx;
          bctrl.wr_ent = '{valid: 1'b1,
                           start: r_start + ADDR_BITS'(HEADER_BYTES),
                           size:  SIZE_W'(rounded_size),
                           owner: in_q.task_id};
          result.alloc_addr = r_start + ADDR_BITS'(HEADER_BYTES);
          result.free_bytes = sum - SIZE_W'(need);
        end else begin
          result.status = 1'b1;
        end
      end
      CMD_FREE: begin
        if (free_ok) begin
          if (ml) begin
            rctrl.mod_en  = 1'b1;
            rctrl.mod_idx = l_idx;
            if (mr) begin
              rctrl.mod_ent = '{valid: 1'b1, start: l_start,
                                size: SIZE_W'(WIDE_W'(l_size) + grow + WIDE_W'(r_size))};
              rctrl.rem_en      = 1'b1;
              rctrl.rem_idx     = r_idx;
              region_count_next = region_count - COUNT_W'(1);
            end else begin
              rctrl.mod_ent = '{valid: 1'b1, start: l_start,
                                size: SIZE_W'(WIDE_W'(l_size) + grow)};
            end
          end else if (mr) begin
            rctrl.mod_en  = 1'b1;
            rctrl.mod_idx = r_idx;
            rctrl.mod_ent = '{valid: 1'b1, start: ADDR_BITS'(hdr),
                              size: SIZE_W'(WIDE_W'(r_size) + grow)};
          end else begin
            rctrl.ins_en      = 1'b1;
            rctrl.ins_idx     = r_found ? r_idx : region_count[IDX_W-1:0];
            rctrl.ins_ent     = '{valid: 1'b1, start: ADDR_BITS'(hdr), size: SIZE_W'(grow)};
            region_count_next = region_count + COUNT_W'(1);
          end
          bctrl.clr_en      = 1'b1;
          bctrl.clr_idx     = b_idx;
          result.free_bytes = sum + SIZE_W'(grow);
        end else begin
          result.status = 1'b1;
        end
      end
      CMD_COUNT: begin
        result.frag_count = frag;
      end
      CMD_INIT: begin
        rctrl.init = 1'b1;
        bctrl.init = 1'b1;
        if (h > SIZE_W'(HEADER_BYTES)) begin
          rctrl.init_ent    = '{valid: 1'b1, start: ADDR_BITS'(HEADER_BYTES),
                                size: h - SIZE_W'(HEADER_BYTES)};
          region_count_next = COUNT_W'(1);
          result.free_bytes = h - SIZE_W'(HEADER_BYTES);
        end else begin
          region_count_next = '0;
          result.free_bytes = '0;
          result.status     = 1'b1;
        end
      end
      default: result.status = 1'b1;
    endcase

    if (!apply_go) begin
      rctrl.init        = 1'b0;
      rctrl.mod_en      = 1'b0;
      rctrl.rem_en      = 1'b0;
      rctrl.ins_en      = 1'b0;
      bctrl.init        = 1'b0;
      bctrl.wr_en       = 1'b0;
      bctrl.clr_en      = 1'b0;
      region_count_next = region_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      heap_bytes   <= HEAP_LIMIT;
      region_count <= COUNT_W'(1);
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      region_count <= region_count_next;
      if (cfg_valid && cfg_ready) begin
        heap_bytes <= cfg_data;
      end
      if (apply_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_data <= result;
    end
  end

  // Scan summary registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q     <= in_data;
      scan_idx <= '0;
      sum      <= '0;
      frag     <= '0;
      r_found  <= 1'b0;
      l_valid  <= 1'b0;
      b_found  <= 1'b0;
    end else if (scanning) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (r_ent[0].valid) begin
        sum <= sum + r_ent[0].size;
        if (r_ent[0].size < in_q.req_size && frag != '1) begin
          frag <= frag + FRAG_W'(1);
        end
      end
      if (!r_found) begin
        if (r_hit) begin
          r_found <= 1'b1;
          r_idx   <= scan_idx;
          r_start <= r_ent[0].start;
          r_size  <= r_ent[0].size;
        end else if (r_ent[0].valid) begin
          l_valid <= 1'b1;
          l_idx   <= scan_idx;
          l_start <= r_ent[0].start;
          l_size  <= r_ent[0].size;
        end
      end
      if (!b_found && b_hit) begin
        b_found <= 1'b1;
        b_idx   <= scan_idx;
        b_size  <= b_ent[0].size;
        b_owner <= b_ent[0].owner;
      end
    end
  end

endmodule
`default_nettype wire

### design/ffha_region_cell.sv
// One entry of the address-ordered free region table.
`default_nettype none
module ffha_region_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ffha_pkg::IDX_W-1:0]  cell_idx,
  input  ffha_pkg::region_ctrl_t      ctrl,
  input  ffha_pkg::region_ent_t       left,
  input  ffha_pkg::region_ent_t       right,
  output ffha_pkg::region_ent_t       ent
);
  import ffha_pkg::*;

  region_ent_t ent_next;

  always_comb begin
    ent_next = ent;
    if (ctrl.rotate) begin
      ent_next = right;
    end else if (ctrl.init) begin
      ent_next = (cell_idx == '0) ? ctrl.init_ent : '0;
    end else begin
      if (ctrl.mod_en && cell_idx == ctrl.mod_idx) begin
        ent_next = ctrl.mod_ent;
      end else if (ctrl.rem_en && cell_idx >= ctrl.rem_idx) begin
        ent_next = right;
      end
      if (ctrl.ins_en) begin
        if (cell_idx == ctrl.ins_idx) begin
          ent_next = ctrl.ins_ent;
        end else if (cell_idx > ctrl.ins_idx) begin
          ent_next = left;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= (cell_idx == '0) ? REGION_RESET_ENT : '0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule
`default_nettype wire

### design/ffha_block_cell.sv
// One entry of the live block table.
`default_nettype none
module ffha_block_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ffha_pkg::IDX_W-1:0]  cell_idx,
  input  ffha_pkg::block_ctrl_t       ctrl,
  input  ffha_pkg::block_ent_t        right,
  output ffha_pkg::block_ent_t        ent
);
  import ffha_pkg::*;

  block_ent_t ent_next;

  always_comb begin
    ent_next = ent;
    if (ctrl.rotate) begin
      ent_next = right;
    end else if (ctrl.init) begin
      ent_next.valid = 1'b0;
    end else if (ctrl.wr_en && cell_idx == ctrl.wr_idx) begin
      ent_next = ctrl.wr_ent;
    end else if (ctrl.clr_en && cell_idx == ctrl.clr_idx) begin
      ent_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    // Payload fields are only read while the entry is valid.
    ent.start <= ent_next.start;
    ent.size  <= ent_next.size;
    ent.owner <= ent_next.owner;
  end

endmodule
`default_nettype wire

### design/ffha_checker.sv
// Port-level checker for the heap allocator top level, with its bind.
`default_nettype none
module ffha_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input ffha_pkg::out_item_t         out_data,
  input logic                        cfg_ready
);
  import ffha_pkg::*;

  // Configuration is only taken while no command is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == !in_stall)
    else $error("cfg_ready does not track the idle input side");

  // A transaction on the input side starts a command that blocks the next one.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // A new result only appears at the end of a command.
  a_result_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no command in flight");

  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.alloc_addr == '0)
    else $error("failed command reports an address");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (.*);
`default_nettype wire

### test/tb_first_fit_heap_allocator_core.sv
// Self-checking testbench for the first-fit heap allocator core.
`default_nettype none
module tb_first_fit_heap_allocator_core;
  import ffha_pkg::*;

  localparam int NUM_RANDOM  = 1130;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;

  first_fit_heap_allocator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the heap state.
  int unsigned heap_size;
  int unsigned rgn_start[$];
  int unsigned rgn_size[$];
  int unsigned blk_start[MAX_BLOCKS];
  int unsigned blk_size[MAX_BLOCKS];
  int unsigned blk_owner[MAX_BLOCKS];
  bit blk_live[MAX_BLOCKS];

  in_item_t pending_cmds[$];
  out_item_t expected_results[$];
  int unsigned live_addrs[$];
  int unsigned live_tasks[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit gen_done = 1'b0;
  bit hold_sender = 1'b0;

  int in_gap = 0;
  int out_gap = 0;
  logic in_stall_q = 1'b0;
  logic out_valid_q = 1'b0;
  logic out_stall_q = 1'b0;

  function automatic bit heap_rebuild();
    int unsigned h;
    h = heap_size > 65536 ? 65536 : heap_size;
    rgn_start.delete();
    rgn_size.delete();
    for (int b = 0; b < MAX_BLOCKS; b++) blk_live[b] = 1'b0;
    if (h <= HEADER_BYTES) return 1'b1;
    rgn_start.push_back(HEADER_BYTES);
    rgn_size.push_back(h - HEADER_BYTES);
    return 1'b0;
  endfunction

  function automatic int unsigned alloc_block(int unsigned req, int unsigned owner,
                                              output bit fail);
    int unsigned real_sz, need, b, s;
    fail = 1'b1;
    if (req == 0) return 0;
    real_sz = (req + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
    need = real_sz + HEADER_BYTES;
    for (b = 0; b < MAX_BLOCKS && blk_live[b]; b++);
    if (b >= MAX_BLOCKS) return 0;
    for (int i = 0; i < rgn_start.size(); i++) begin
      if (rgn_size[i] < need) continue;
      s = rgn_start[i];
      if (rgn_size[i] == need) begin
        rgn_start.delete(i);
        rgn_size.delete(i);
      end else begin
        rgn_start[i] = (s + need) & 16'hFFFF;
        rgn_size[i] = rgn_size[i] - need;
      end
      blk_start[b] = (s + HEADER_BYTES) & 16'hFFFF;
      blk_size[b] = real_sz;
      blk_owner[b] = owner;
      blk_live[b] = 1'b1;
      fail = 1'b0;
      return blk_start[b];
    end
    return 0;
  endfunction

  function automatic bit free_block(int unsigned addr, int unsigned owner);
    int b, i, n;
    int unsigned hdr, bend, grow;
    bit has_l, has_r, ml, mr;
    if (addr == 0) return 1'b1;
    for (b = 0; b < MAX_BLOCKS; b++)
      if (blk_live[b] && blk_start[b] == addr) break;
    if (b >= MAX_BLOCKS) return 1'b1;
    if (blk_owner[b] != owner) return 1'b1;
    hdr = addr - HEADER_BYTES;
    bend = addr + blk_size[b];
    grow = blk_size[b] + HEADER_BYTES;
    n = rgn_start.size();
    for (i = 0; i < n && rgn_start[i] < addr; i++);
    has_l = i > 0;
    has_r = i < n;
    if (has_l && rgn_start[i-1] + rgn_size[i-1] > hdr) return 1'b1;
    if (has_r && bend > rgn_start[i]) return 1'b1;
    ml = has_l && rgn_start[i-1] + rgn_size[i-1] == hdr;
    mr = has_r && bend == rgn_start[i];
    if (ml && mr) begin
      rgn_size[i-1] += grow + rgn_size[i];
      rgn_start.delete(i);
      rgn_size.delete(i);
    end else if (ml) begin
      rgn_size[i-1] += grow;
    end else if (mr) begin
      rgn_start[i] = hdr;
      rgn_size[i] += grow;
    end else begin
      if (n >= MAX_REGIONS) return 1'b1;
      rgn_start.insert(i, hdr);
      rgn_size.insert(i, grow);
    end
    blk_live[b] = 1'b0;
    return 1'b0;
  endfunction

  function automatic out_item_t predict_result(in_item_t cmd);
    out_item_t r;
    bit fail;
    int unsigned frag, total;
    r = '0;
    fail = 1'b0;
    frag = 0;
    case (cmd.cmd)
      CMD_ALLOC: r.alloc_addr = alloc_block(cmd.req_size, cmd.task_id, fail);
      CMD_FREE: fail = free_block(cmd.block_addr, cmd.task_id);
      CMD_COUNT: begin
        foreach (rgn_size[i]) if (rgn_size[i] < cmd.req_size) frag++;
        if (frag > 127) frag = 127;
      end
      default: fail = heap_rebuild();
    endcase
    total = 0;
    foreach (rgn_size[i]) total += rgn_size[i];
    r.status = fail;
    r.frag_count = frag[FRAG_W-1:0];
    r.free_bytes = total[SIZE_W-1:0];
    return r;
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] op, int unsigned req,
                                        int unsigned addr, int unsigned owner);
    in_item_t c;
    c.cmd = op;
    c.req_size = req[SIZE_W-1:0];
    c.block_addr = addr[ADDR_BITS-1:0];
    c.task_id = owner[OWNER_W-1:0];
    return c;
  endfunction

  // Commands are predicted when generated; the driver sends them in order.
  task automatic queue_cmd(in_item_t c);
    out_item_t r;
    r = predict_result(c);
    expected_results.push_back(r);
    pending_cmds.push_back(c);
    if (c.cmd == CMD_ALLOC && !r.status) begin
      live_addrs.push_back(r.alloc_addr);
      live_tasks.push_back(c.task_id);
    end else if (c.cmd == CMD_INIT) begin
      live_addrs.delete();
      live_tasks.delete();
    end
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_heap(int unsigned bytes);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= bytes[SIZE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    heap_size = bytes;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random command mix, weighted toward allocations and frees of live blocks.
  task automatic random_cmd(int unsigned max_req);
    int unsigned k, sel;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      queue_cmd(make_cmd(CMD_ALLOC, $urandom_range(0, 9) == 0 ? $urandom_range(0, 131071)
                         : $urandom_range(1, max_req), 0, $urandom_range(0, 3)));
    end else if (k < 85 && live_addrs.size() != 0) begin
      sel = $urandom_range(0, live_addrs.size() - 1);
      if ($urandom_range(0, 9) == 0) begin
        queue_cmd(make_cmd(CMD_FREE, 0, live_addrs[sel], live_tasks[sel] ^ 1));
      end else begin
        queue_cmd(make_cmd(CMD_FREE, $urandom, live_addrs[sel], live_tasks[sel]));
        live_addrs.delete(sel);
        live_tasks.delete(sel);
      end
    end else if (k < 92) begin
      queue_cmd(make_cmd(CMD_FREE, 0, $urandom_range(0, 65535), $urandom_range(0, 255)));
    end else if (k < 99) begin
      queue_cmd(make_cmd(CMD_COUNT, $urandom_range(0, 131071) >> $urandom_range(0, 12), 0,
                         $urandom_range(0, 255)));
    end else begin
      queue_cmd(make_cmd(CMD_INIT, $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    heap_size = 65536;
    void'(heap_rebuild());
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes of each field and the error cases.
    queue_cmd(make_cmd(CMD_COUNT, 131071, 0, 0));
    queue_cmd(make_cmd(CMD_ALLOC, 0, 0, 1));
    queue_cmd(make_cmd(CMD_ALLOC, 131071, 65535, 255));
    queue_cmd(make_cmd(CMD_ALLOC, 1, 0, 7));
    queue_cmd(make_cmd(CMD_ALLOC, 24, 0, 8));
    queue_cmd(make_cmd(CMD_ALLOC, 65504, 0, 9));
    queue_cmd(make_cmd(CMD_FREE, 0, 0, 7));
    queue_cmd(make_cmd(CMD_FREE, 0, 65535, 7));
    queue_cmd(make_cmd(CMD_FREE, 0, 16 + HEADER_BYTES, 8));
    queue_cmd(make_cmd(CMD_FREE, 0, HEADER_BYTES, 8));
    queue_cmd(make_cmd(CMD_FREE, 0, 48, 8));
    queue_cmd(make_cmd(CMD_FREE, 0, 32, 7));
    queue_cmd(make_cmd(CMD_COUNT, 65, 0, 0));
    queue_cmd(make_cmd(CMD_INIT, 0, 0, 0));
    queue_cmd(make_cmd(CMD_ALLOC, 65504, 0, 3));
    queue_cmd(make_cmd(CMD_COUNT, 0, 0, 0));
    drain();

    set_heap(0);
    queue_cmd(make_cmd(CMD_INIT, 0, 0, 0));
    queue_cmd(make_cmd(CMD_ALLOC, 8, 0, 0));
    queue_cmd(make_cmd(CMD_COUNT, 100, 0, 0));
    drain();
    set_heap(131071);
    queue_cmd(make_cmd(CMD_INIT, 0, 0, 0));
    drain();

    // Random phases over several heap sizes; small heaps stress exact fits.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_heap(65536);
        1: set_heap(HEADER_BYTES + 1);
        2: set_heap($urandom_range(256, 1024) & ~7);
        3: set_heap($urandom_range(17, 131071));
        default: set_heap(4096);
      endcase
      queue_cmd(make_cmd(CMD_INIT, 0, 0, 0));
      for (int n = 0; n < NUM_RANDOM / 5; n++) begin
        random_cmd(ph == 0 ? 600 : (ph == 3 ? 2000 : 64));
        if (n == 100) begin
          hold_sender = 1'b1;
          while (pending_cmds.size() != 0) @(posedge clk);
          hold_sender = 1'b0;
        end
        if (n % 50 == 0) while (pending_cmds.size() > 4) @(posedge clk);
      end
      drain();
    end
    gen_done = 1'b1;
  end

  // Driver: presents queued commands with random gaps.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        pending_cmds.pop_front();
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end
      if ((in_valid && in_stall_q) || (pending_cmds.size() != 0 && in_gap == 0 &&
          !(hold_sender && expected_results.size() > pending_cmds.size()))) begin
        in_valid <= 1'b1;
        in_data <= pending_cmds[0];
      end else begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap--;
      end else begin
        out_stall <= 1'b0;
      end
      if (out_valid_q && !out_stall_q)
        out_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    in_stall_q <= in_stall;
    out_valid_q <= out_valid;
    out_stall_q <= out_stall;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.alloc_addr !== want.alloc_addr)
          report_mismatch("alloc_addr", out_data.alloc_addr, want.alloc_addr);
        if (out_data.frag_count !== want.frag_count)
          report_mismatch("frag_count", out_data.frag_count, want.frag_count);
        if (out_data.free_bytes !== want.free_bytes)
          report_mismatch("free_bytes", out_data.free_bytes, want.free_bytes);
      end
    end
    if (gen_done) begin
      if (errors == 0 && expected_results.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
    end else if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end
endmodule
`default_nettype wire
